[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the visibility marker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is high
`define CHK_CLK_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// clocked check that also holds during reset
`define CHK_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`else

`define CHK_CLK_RST(lbl, clk, rst, prop)
`define CHK_CLK(lbl, clk, prop)

`endif

`endif

[rtl/core/idbvm_pkg.sv]
// ----------------------------------------------------------------------------
// idbvm_pkg
// Types and constants of the id buffer visibility marker.
// ----------------------------------------------------------------------------
package idbvm_pkg;

  // field widths
  localparam int KIND_W = 3;
  localparam int CODE_W = 24;
  localparam int VTX_W  = 15;
  localparam int LIMIT_W = 32;

  // capacities
  localparam int MAX_FACES    = 65536;
  localparam int MAX_VERTICES = 32768;
  localparam int FACE_AW      = $clog2(MAX_FACES);
  localparam int VTX_AW       = $clog2(MAX_VERTICES);

  // clearing sweep covers the larger bitmap
  localparam int SWEEP_DEPTH = (MAX_FACES > MAX_VERTICES) ? MAX_FACES : MAX_VERTICES;
  localparam int SWEEP_AW    = $clog2(SWEEP_DEPTH);

  // face table entry: three corner indices
  localparam int TBL_W = 3 * VTX_W;

  localparam logic [CODE_W-1:0] BG_CODE = 24'hFF_FFFF;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD         = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY_FACE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY_VERTEX = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] face_code;
    logic [VTX_W-1:0]  corner_first;
    logic [VTX_W-1:0]  corner_second;
    logic [VTX_W-1:0]  corner_third;
    logic [VTX_W-1:0]  vertex_query;
  } req_t;

  typedef struct packed {
    logic is_background;
    logic out_of_range;
    logic newly_marked;
    logic face_seen;
    logic vertex_seen;
  } res_t;

endpackage

[rtl/core/idbvm_ram.sv]
// ----------------------------------------------------------------------------
// idbvm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module idbvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/idbvm_cmp_unit.sv]
// ----------------------------------------------------------------------------
// idbvm_cmp_unit
// Shared range compare, checks an index against a capacity limit.
// ----------------------------------------------------------------------------
module idbvm_cmp_unit (
  input  logic [idbvm_pkg::CODE_W-1:0]  operand,
  input  logic [idbvm_pkg::LIMIT_W-1:0] limit,
  output logic                          in_range
);

  import idbvm_pkg::*;

  // index below capacity
  assign in_range = (LIMIT_W'(operand) < limit);

endmodule

[rtl/core/id_buffer_visibility_marker_core.sv]
// ----------------------------------------------------------------------------
// id_buffer_visibility_marker_core
// Marks visible faces and vertices from a stream of face id pixels.
// ----------------------------------------------------------------------------
// Where each request ends: load, background, rejected or unused kind in
// S_CHECK, query or already seen pixel in S_READ, pixel on a new face in
// S_MARK (three corner writes through the single vertex bitmap write port),
// clear in S_SWEEP. One request at a time: a new request is taken in the
// cycle done is high. After reset both bitmaps are swept to zero, busy
// stays high for the sweep. Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module id_buffer_visibility_marker_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  idbvm_pkg::req_t   req,
  output logic              busy,
  output logic              done,
  output idbvm_pkg::res_t   result
);

  import idbvm_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_MARK
  } state_t;

  state_t               state;
  req_t                 rq;
  logic [SWEEP_AW-1:0]  cnt;
  logic [1:0]           cidx;
  logic [TBL_W-1:0]     corners;
  logic                 sweep_reply;

  // result staging
  logic                 done_next;
  res_t                 result_next;

  // compare unit operands
  logic [CODE_W-1:0]    cmp_op;
  logic [LIMIT_W-1:0]   cmp_limit;
  logic                 in_range;
  logic [VTX_W-1:0]     corner_sel;

  // memory ports
  logic                 tbl_we;
  logic                 mem_re;
  logic [TBL_W-1:0]     tbl_rd;
  logic                 seen_we;
  logic [FACE_AW-1:0]   seen_waddr;
  logic                 seen_wdata;
  logic                 seen_rd;
  logic                 vtx_we;
  logic [VTX_AW-1:0]    vtx_waddr;
  logic                 vtx_wdata;
  logic                 vtx_rd;

  logic                 is_bg;
  logic [FACE_AW-1:0]   face_addr;

  assign busy      = (state != S_IDLE);
  assign is_bg     = (rq.face_code == BG_CODE);
  assign face_addr = FACE_AW'(rq.face_code);
  assign mem_re    = (state == S_CHECK);

  // corner picked by the mark step
  always_comb begin
    case (cidx)
      2'd0:    corner_sel = corners[TBL_W-1 -: VTX_W];
      2'd1:    corner_sel = corners[TBL_W-VTX_W-1 -: VTX_W];
      default: corner_sel = corners[VTX_W-1:0];
    endcase
  end

  // operand select for the shared compare
  always_comb begin
    cmp_op    = rq.face_code;
    cmp_limit = LIMIT_W'(MAX_FACES);
    case (state)
      S_CHECK: begin
        if (rq.kind == KIND_QUERY_VERTEX) begin
          cmp_op    = CODE_W'(rq.vertex_query);
          cmp_limit = LIMIT_W'(MAX_VERTICES);
        end
      end
      S_MARK: begin
        cmp_op    = CODE_W'(corner_sel);
        cmp_limit = LIMIT_W'(MAX_VERTICES);
      end
      default: begin
        cmp_op    = rq.face_code;
        cmp_limit = LIMIT_W'(MAX_FACES);
      end
    endcase
  end

  idbvm_cmp_unit u_cmp (
    .operand  (cmp_op),
    .limit    (cmp_limit),
    .in_range (in_range)
  );

  // memory write control
  always_comb begin
    tbl_we     = (state == S_CHECK) && (rq.kind == KIND_LOAD) && in_range;
    seen_we    = 1'b0;
    seen_waddr = face_addr;
    seen_wdata = 1'b1;
    vtx_we     = 1'b0;
    vtx_waddr  = VTX_AW'(corner_sel);
    vtx_wdata  = 1'b1;
    case (state)
      S_SWEEP: begin
        seen_we    = (LIMIT_W'(cnt) < LIMIT_W'(MAX_FACES));
        seen_waddr = FACE_AW'(cnt);
        seen_wdata = 1'b0;
        vtx_we     = (LIMIT_W'(cnt) < LIMIT_W'(MAX_VERTICES));
        vtx_waddr  = VTX_AW'(cnt);
        vtx_wdata  = 1'b0;
      end
      S_READ: begin
        seen_we = (rq.kind == KIND_PIXEL) && !seen_rd;
      end
      S_MARK: begin
        vtx_we = in_range;
      end
      default: begin
        seen_we = 1'b0;
        vtx_we  = 1'b0;
      end
    endcase
  end

  // face corner table
  idbvm_ram #(.WIDTH(TBL_W), .DEPTH(MAX_FACES)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (face_addr),
    .wdata ({rq.corner_first, rq.corner_second, rq.corner_third}),
    .re    (mem_re),
    .raddr (face_addr),
    .rdata (tbl_rd)
  );

  // face seen bitmap
  idbvm_ram #(.WIDTH(1), .DEPTH(MAX_FACES)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (mem_re),
    .raddr (face_addr),
    .rdata (seen_rd)
  );

  // vertex visible bitmap
  idbvm_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vtx (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (vtx_waddr),
    .wdata (vtx_wdata),
    .re    (mem_re),
    .raddr (VTX_AW'(rq.vertex_query)),
    .rdata (vtx_rd)
  );

  // result and done for the step that finishes a request
  always_comb begin
    done_next   = 1'b0;
    result_next = result;
    case (state)
      S_SWEEP: begin
        if ((cnt == SWEEP_AW'(SWEEP_DEPTH - 1)) && sweep_reply) begin
          done_next   = 1'b1;
          result_next = '0;
        end
      end
      S_CHECK: begin
        result_next = '0;
        case (rq.kind)
          KIND_LOAD: begin
            done_next                = 1'b1;
            result_next.out_of_range = !in_range;
          end
          KIND_PIXEL: begin
            if (is_bg) begin
              done_next                 = 1'b1;
              result_next.is_background = 1'b1;
            end else if (!in_range) begin
              done_next                = 1'b1;
              result_next.out_of_range = 1'b1;
            end
          end
          KIND_QUERY_FACE, KIND_QUERY_VERTEX: begin
            if (!in_range) begin
              done_next                = 1'b1;
              result_next.out_of_range = 1'b1;
            end
          end
          KIND_CLEAR: begin
            done_next = 1'b0;
          end
          default: begin
            done_next = 1'b1;
          end
        endcase
      end
      S_READ: begin
        result_next = '0;
        case (rq.kind)
          KIND_PIXEL: begin
            if (seen_rd) begin
              done_next             = 1'b1;
              result_next.face_seen = 1'b1;
            end
          end
          KIND_QUERY_FACE: begin
            done_next             = 1'b1;
            result_next.face_seen = seen_rd;
          end
          default: begin
            done_next               = 1'b1;
            result_next.vertex_seen = vtx_rd;
          end
        endcase
      end
      S_MARK: begin
        if (cidx == 2'd2) begin
          done_next                = 1'b1;
          result_next              = '0;
          result_next.newly_marked = 1'b1;
          result_next.face_seen    = 1'b1;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      cnt         <= '0;
      cidx        <= '0;
      done        <= 1'b0;
      sweep_reply <= 1'b0;
    end else begin
      done   <= done_next;
      result <= result_next;
      case (state)
        S_SWEEP: begin
          if (cnt == SWEEP_AW'(SWEEP_DEPTH - 1)) begin
            state       <= S_IDLE;
            sweep_reply <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            rq    <= req;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          case (rq.kind)
            KIND_LOAD: begin
              state <= S_IDLE;
            end
            KIND_PIXEL: begin
              if (is_bg || !in_range) begin
                state <= S_IDLE;
              end else begin
                state <= S_READ;
              end
            end
            KIND_QUERY_FACE, KIND_QUERY_VERTEX: begin
              if (!in_range) begin
                state <= S_IDLE;
              end else begin
                state <= S_READ;
              end
            end
            KIND_CLEAR: begin
              cnt         <= '0;
              sweep_reply <= 1'b1;
              state       <= S_SWEEP;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_READ: begin
          if ((rq.kind == KIND_PIXEL) && !seen_rd) begin
            corners <= tbl_rd;
            cidx    <= '0;
            state   <= S_MARK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MARK: begin
          cidx <= cidx + 1'b1;
          if (cidx == 2'd2) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `CHK_CLK_RST(a_done_in_idle, clk, rst, done |-> (state == S_IDLE))
  `CHK_CLK_RST(a_no_done_after_accept, clk, rst, (start && !busy) |=> !done)
  `CHK_CLK_RST(a_new_implies_seen, clk, rst, (done && result.newly_marked) |-> result.face_seen)
  `CHK_CLK_RST(a_vtx_write_phase, clk, rst, vtx_we |-> (state == S_MARK || state == S_SWEEP))
  `CHK_CLK(a_reset_busy, clk, $past(rst) |-> busy)

endmodule
